// ----- rtl/rhc_pkg.sv -----
// ----------------------------------------------------------------------------
// RGB/HSL converter package
// Shared constants for hue geometry, mode codes and divider pipeline sizing.
// ----------------------------------------------------------------------------
package rhc_pkg;

    // Hue is carried in quarter degrees.
    localparam int HUE_W = 11;
    localparam logic [HUE_W-1:0] HUE_TURN  = 11'd1440;
    localparam logic [HUE_W-1:0] HUE_THIRD = 11'd480;
    localparam logic [HUE_W-1:0] HUE_RISE  = 11'd240;
    localparam logic [HUE_W-1:0] HUE_FLAT  = 11'd720;
    localparam logic [HUE_W-1:0] HUE_FALL  = 11'd960;
    localparam logic [HUE_W-1:0] HUE_TWO_THIRDS = 11'd960;

    // Direction register codes.
    localparam logic DIR_RGB2HSL = 1'b0;
    localparam logic DIR_HSL2RGB = 1'b1;

    // Quotient bits resolved per divider pipeline stage.
    localparam int DIV_STEPS = 4;

    function automatic int quot_bits(input int n);
        return (n > HUE_W) ? n : HUE_W;
    endfunction

    function automatic int div_stages(input int n);
        return (quot_bits(n) + DIV_STEPS - 1) / DIV_STEPS;
    endfunction

    // Cycles from an accepted start to the edge that takes the result.
    function automatic int core_latency(input int n);
        return div_stages(n) + 5;
    endfunction

    // Weight of the span term of the piecewise hue-to-channel rule, 0..240.
    function automatic logic [7:0] hue_weight(input logic [HUE_W-1:0] t);
        logic [HUE_W-1:0] fall;
        fall = HUE_FALL - t;
        if (t < HUE_RISE) begin
            return t[7:0];
        end
        else if (t < HUE_FLAT) begin
            return HUE_RISE[7:0];
        end
        else if (t < HUE_FALL) begin
            return fall[7:0];
        end
        else begin
            return 8'd0;
        end
    endfunction

endpackage

// ----- rtl/rhc_div.sv -----
// ----------------------------------------------------------------------------
// Pipelined restoring divider
// Unsigned floor(x / y), SPS quotient bits per register stage. The caller
// guarantees that the quotient fits in QW bits.
// ----------------------------------------------------------------------------
module rhc_div #(
    parameter int XW     = 25,
    parameter int DW     = 17,
    parameter int QW     = 11,
    parameter int SPS    = 4,
    parameter int STAGES = 3
) (
    input  logic          clk,
    input  logic [XW-1:0] x,
    input  logic [DW-1:0] y,
    output logic [QW-1:0] q
);

    logic [XW+DW-1:0] x_ext;
    logic [DW-1:0]    rem_in   [STAGES];
    logic [QW-1:0]    acc_in   [STAGES];
    logic [DW-1:0]    y_in     [STAGES];
    logic [DW-1:0]    rem_next [STAGES];
    logic [QW-1:0]    acc_next [STAGES];
    logic [DW-1:0]    rem_reg  [STAGES];
    logic [QW-1:0]    acc_reg  [STAGES];
    logic [DW-1:0]    y_reg    [STAGES];

    // The part of the dividend above the quotient bits is already below y.
    assign x_ext     = {{DW{1'b0}}, x};
    assign rem_in[0] = x_ext[QW +: DW];
    assign acc_in[0] = x[QW-1:0];
    assign y_in[0]   = y;

    genvar s;
    generate
        for (s = 1; s < STAGES; s++) begin : g_link
            assign rem_in[s] = rem_reg[s-1];
            assign acc_in[s] = acc_reg[s-1];
            assign y_in[s]   = y_reg[s-1];
        end

        for (s = 0; s < STAGES; s++) begin : g_stage
            // The accumulator shifts dividend bits out at the top and takes
            // quotient bits in at the bottom.
            always_comb
            begin : step
                logic [DW:0]   trial;
                logic [DW-1:0] r;
                logic [QW-1:0] a;
                r     = rem_in[s];
                a     = acc_in[s];
                trial = '0;
                for (int k = 0; k < SPS; k++)
                begin
                    if (s * SPS + k < QW)
                    begin
                        trial = {r, a[QW-1]};
                        a     = {a[QW-2:0], 1'b0};
                        if (trial >= {1'b0, y_in[s]})
                        begin
                            trial = trial - {1'b0, y_in[s]};
                            a[0]  = 1'b1;
                        end
                        r = trial[DW-1:0];
                    end
                end
                rem_next[s] = r;
                acc_next[s] = a;
            end

            always_ff @(posedge clk)
            begin
                rem_reg[s] <= rem_next[s];
                acc_reg[s] <= acc_next[s];
                y_reg[s]   <= y_in[s];
            end
        end
    endgenerate

    assign q = acc_reg[STAGES-1];

endmodule

// ----- rtl/rgb_hsl_color_converter_core.sv -----
// ----------------------------------------------------------------------------
// RGB/HSL color converter core
// Converts one pixel per clock between RGB and HSL in exact fixed point.
// ----------------------------------------------------------------------------
// Usage:
// A pixel is taken at a rising clock edge where start is high and busy is low.
// busy never rises, so a new pixel may be offered in every cycle. The direction
// register is written through cfg_valid/cfg_data (cfg_ready is always high) and
// selects RGB to HSL (0) or HSL to RGB (1); it should only be written while no
// transaction is in flight. Each result is shown for exactly one cycle with done
// high, in the order the pixels came in. The receiver cannot hold results off,
// and nothing in the pipeline ever stalls.
// Throughput is one pixel per cycle. The depth is set by the pipelined
// restoring divider, which resolves four quotient bits per stage; four front
// stages handle channel ordering, the hue numerators and HSL products, the
// P/Q and divider operands, and the divider lane select, and one output
// stage follows. Reset clears the direction register and every valid bit,
// so transactions in flight at reset are dropped and no done strobe follows.
// ----------------------------------------------------------------------------
module rgb_hsl_color_converter_core #(
    parameter int CHANNEL_BITS = 8
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      cfg_valid,
    output logic                      cfg_ready,
    input  logic                      cfg_data,
    input  logic                      start,
    output logic                      busy,
    input  logic [CHANNEL_BITS-1:0]   red_in,
    input  logic [CHANNEL_BITS-1:0]   green_in,
    input  logic [CHANNEL_BITS-1:0]   blue_in,
    input  logic [rhc_pkg::HUE_W-1:0] hue_in,
    input  logic [CHANNEL_BITS-1:0]   sat_in,
    input  logic [CHANNEL_BITS-1:0]   light_in,
    output logic                      done,
    output logic [rhc_pkg::HUE_W-1:0] hue_out,
    output logic [CHANNEL_BITS-1:0]   sat_out,
    output logic [CHANNEL_BITS-1:0]   light_out,
    output logic [CHANNEL_BITS-1:0]   red_out,
    output logic [CHANNEL_BITS-1:0]   green_out,
    output logic [CHANNEL_BITS-1:0]   blue_out
);

    import rhc_pkg::*;

    localparam int N   = CHANNEL_BITS;
    localparam int QW  = quot_bits(CHANNEL_BITS);
    localparam int DS  = div_stages(CHANNEL_BITS);
    // Dividend and divisor widths cover both modes; the HSL to RGB dividend
    // 2*(240*P + span*w) + 240*M is the widest.
    localparam int XW  = 2 * CHANNEL_BITS + 9;
    localparam int DW  = CHANNEL_BITS + 9;
    localparam int PW  = 2 * CHANNEL_BITS;
    localparam int HSW = CHANNEL_BITS + 12;
    localparam int HUW = CHANNEL_BITS + 11;

    localparam logic [N-1:0]  CH_MAX   = '1;
    localparam logic [XW-1:0] CH_ROUND = XW'(240 * ((1 << CHANNEL_BITS) - 1));
    localparam logic [DW-1:0] CH_DIV   = DW'(480 * ((1 << CHANNEL_BITS) - 1));

    // Which channel holds the maximum; red wins ties, then green.
    localparam logic [1:0] SEL_RED   = 2'd0;
    localparam logic [1:0] SEL_GREEN = 2'd1;
    localparam logic [1:0] SEL_BLUE  = 2'd2;

    typedef struct packed {
        logic         mode;
        logic         gray;
        logic [N-1:0] light;
    } sb_t;

    function automatic logic [N-1:0] sat_ch(input logic [QW-1:0] v);
        return (v > QW'(CH_MAX)) ? CH_MAX : v[N-1:0];
    endfunction

    // Rounded dividend for one output channel: 2*(240*P + span*w) + 240*M,
    // later divided by 480*M.
    function automatic logic [XW-1:0] chan_dividend(input logic [PW-1:0] p,
                                                    input logic [PW-1:0] span,
                                                    input logic [7:0]    w);
        logic [PW+7:0] prod;
        logic [XW-1:0] pe;
        logic [XW-1:0] num;
        prod = span * w;
        pe   = XW'(p);
        num  = (pe << 8) - (pe << 4) + XW'(prod);
        return (num << 1) + CH_ROUND;
    endfunction

    // ------------------------------------------------------------------
    // Configuration and handshake
    // ------------------------------------------------------------------
    logic direction_reg;
    logic accept;

    assign cfg_ready = 1'b1;
    assign busy      = 1'b0;
    assign accept    = start & ~busy;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            direction_reg <= DIR_RGB2HSL;
        end
        else if (cfg_valid && cfg_ready)
        begin
            direction_reg <= cfg_data;
        end
    end

    // ------------------------------------------------------------------
    // Stage 1: order the channels and fold the hue into one turn.
    // ------------------------------------------------------------------
    logic [1:0]       sel_next;
    logic [N-1:0]     max_next;
    logic [N-1:0]     min_next;
    logic [HUE_W-1:0] hmod_next;

    always_comb
    begin
        if (red_in >= green_in && red_in >= blue_in)
        begin
            sel_next = SEL_RED;
            max_next = red_in;
        end
        else if (green_in >= blue_in)
        begin
            sel_next = SEL_GREEN;
            max_next = green_in;
        end
        else
        begin
            sel_next = SEL_BLUE;
            max_next = blue_in;
        end

        if (red_in <= green_in && red_in <= blue_in)
        begin
            min_next = red_in;
        end
        else if (green_in <= blue_in)
        begin
            min_next = green_in;
        end
        else
        begin
            min_next = blue_in;
        end

        hmod_next = (hue_in >= HUE_TURN) ? hue_in - HUE_TURN : hue_in;
    end

    logic             s1_valid_reg;
    logic             s1_mode_reg;
    logic [1:0]       s1_sel_reg;
    logic [N-1:0]     s1_red_reg;
    logic [N-1:0]     s1_green_reg;
    logic [N-1:0]     s1_blue_reg;
    logic [N-1:0]     s1_max_reg;
    logic [N-1:0]     s1_min_reg;
    logic [HUE_W-1:0] s1_hue_reg;
    logic [N-1:0]     s1_sat_reg;
    logic [N-1:0]     s1_light_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= accept;
        end
    end

    always_ff @(posedge clk)
    begin
        s1_mode_reg  <= direction_reg;
        s1_sel_reg   <= sel_next;
        s1_red_reg   <= red_in;
        s1_green_reg <= green_in;
        s1_blue_reg  <= blue_in;
        s1_max_reg   <= max_next;
        s1_min_reg   <= min_next;
        s1_hue_reg   <= hmod_next;
        s1_sat_reg   <= sat_in;
        s1_light_reg <= light_in;
    end

    // ------------------------------------------------------------------
    // Stage 2: RGB to HSL spread, lightness and hue numerator;
    // HSL to RGB products and per-channel hue weights.
    // ------------------------------------------------------------------
    logic [N-1:0]     d_next;
    logic [N:0]       sum_next;
    logic [N+1:0]     sum_rnd;
    logic [N-1:0]     den_next;
    logic [N-1:0]     hi_op;
    logic [N-1:0]     lo_op;
    logic [HSW-1:0]   d_wide;
    logic [HSW-1:0]   off_u;
    logic signed [HSW-1:0] diff_s;
    logic signed [HSW-1:0] num_s;
    logic [HUW-1:0]   hnum_next;
    logic [HUE_W:0]   tr_sum;
    logic [HUE_W:0]   tr_fold;
    logic [HUE_W-1:0] tb_val;

    always_comb
    begin
        d_next   = s1_max_reg - s1_min_reg;
        sum_next = {1'b0, s1_max_reg} + {1'b0, s1_min_reg};
        sum_rnd  = {1'b0, sum_next} + (N+2)'(1);
        den_next = (sum_next > {1'b0, CH_MAX}) ? N'({CH_MAX, 1'b0} - sum_next)
                                               : sum_next[N-1:0];
        d_wide   = HSW'(d_next);

        case (s1_sel_reg)
            SEL_RED:
            begin
                hi_op = s1_green_reg;
                lo_op = s1_blue_reg;
                // Wraps the negative side of the red sector into 300..360 degrees.
                off_u = (s1_green_reg < s1_blue_reg)
                      ? (d_wide << 10) + (d_wide << 9) - (d_wide << 7) + (d_wide << 5)
                      : '0;
            end
            SEL_GREEN:
            begin
                hi_op = s1_blue_reg;
                lo_op = s1_red_reg;
                off_u = (d_wide << 9) - (d_wide << 5);
            end
            default:
            begin
                hi_op = s1_red_reg;
                lo_op = s1_green_reg;
                off_u = (d_wide << 10) - (d_wide << 6);
            end
        endcase

        diff_s    = $signed(HSW'(hi_op)) - $signed(HSW'(lo_op));
        num_s     = (diff_s <<< 8) - (diff_s <<< 4) + $signed(off_u);
        hnum_next = num_s[HSW-1] ? '0 : num_s[HUW-1:0];

        tr_sum  = {1'b0, s1_hue_reg} + {1'b0, HUE_THIRD};
        tr_fold = (tr_sum > {1'b0, HUE_TURN}) ? tr_sum - {1'b0, HUE_TURN} : tr_sum;
        tb_val  = (s1_hue_reg >= HUE_THIRD) ? s1_hue_reg - HUE_THIRD
                                            : s1_hue_reg + HUE_TWO_THIRDS;
    end

    logic           s2_valid_reg;
    logic           s2_mode_reg;
    logic           s2_gray_reg;
    logic [N-1:0]   s2_light_reg;
    logic [N-1:0]   s2_d_reg;
    logic [N-1:0]   s2_den_reg;
    logic [HUW-1:0] s2_hnum_reg;
    logic [PW-1:0]  s2_ls_reg;
    logic [PW-1:0]  s2_lm_reg;
    logic [PW-1:0]  s2_sm_reg;
    logic           s2_llow_reg;
    logic [7:0]     s2_wr_reg;
    logic [7:0]     s2_wg_reg;
    logic [7:0]     s2_wb_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s2_valid_reg <= 1'b0;
        end
        else
        begin
            s2_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        s2_mode_reg  <= s1_mode_reg;
        s2_gray_reg  <= (s1_max_reg == s1_min_reg);
        s2_light_reg <= sum_rnd[N:1];
        s2_d_reg     <= d_next;
        s2_den_reg   <= den_next;
        s2_hnum_reg  <= hnum_next;
        s2_ls_reg    <= s1_light_reg * s1_sat_reg;
        s2_lm_reg    <= {s1_light_reg, {N{1'b0}}} - PW'(s1_light_reg);
        s2_sm_reg    <= {s1_sat_reg, {N{1'b0}}} - PW'(s1_sat_reg);
        s2_llow_reg  <= ({s1_light_reg, 1'b0} < {1'b0, CH_MAX});
        s2_wr_reg    <= hue_weight(tr_fold[HUE_W-1:0]);
        s2_wg_reg    <= hue_weight(s1_hue_reg);
        s2_wb_reg    <= hue_weight(tb_val);
    end

    // ------------------------------------------------------------------
    // Stage 3: RGB to HSL divider operands; HSL to RGB P, Q and span.
    // P and Q are scaled by M*M and always fit 2*N bits, so the modular
    // arithmetic below is exact.
    // ------------------------------------------------------------------
    logic [PW-1:0] md_val;
    logic [PW-1:0] q_val;
    logic [PW-1:0] p_val;

    always_comb
    begin
        md_val = {s2_d_reg, {N{1'b0}}} - PW'(s2_d_reg);
        q_val  = s2_llow_reg ? s2_lm_reg + s2_ls_reg
                             : s2_lm_reg + s2_sm_reg - s2_ls_reg;
        p_val  = PW'({s2_lm_reg, 1'b0}) - q_val;
    end

    logic          s3_valid_reg;
    sb_t           s3_sb_reg;
    logic [XW-1:0] s3_xhue_reg;
    logic [DW-1:0] s3_yhue_reg;
    logic [XW-1:0] s3_xsat_reg;
    logic [DW-1:0] s3_ysat_reg;
    logic [PW-1:0] s3_p_reg;
    logic [PW-1:0] s3_span_reg;
    logic [7:0]    s3_wr_reg;
    logic [7:0]    s3_wg_reg;
    logic [7:0]    s3_wb_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s3_valid_reg <= 1'b0;
        end
        else
        begin
            s3_valid_reg <= s2_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        s3_sb_reg.mode  <= s2_mode_reg;
        s3_sb_reg.gray  <= s2_gray_reg;
        s3_sb_reg.light <= s2_light_reg;
        s3_xhue_reg     <= XW'({s2_hnum_reg, 1'b0}) + XW'(s2_d_reg);
        s3_yhue_reg     <= DW'({s2_d_reg, 1'b0});
        s3_xsat_reg     <= XW'({md_val, 1'b0}) + XW'(s2_den_reg);
        s3_ysat_reg     <= DW'({s2_den_reg, 1'b0});
        s3_p_reg        <= p_val;
        s3_span_reg     <= q_val - p_val;
        s3_wr_reg       <= s2_wr_reg;
        s3_wg_reg       <= s2_wg_reg;
        s3_wb_reg       <= s2_wb_reg;
    end

    // ------------------------------------------------------------------
    // Stage 4: divider lane operands. In RGB to HSL mode lane A divides for
    // hue and lane B for saturation; in HSL to RGB mode the lanes carry red,
    // green and blue, all over the constant 480*M.
    // ------------------------------------------------------------------
    logic [XW-1:0] xa_next;
    logic [XW-1:0] xb_next;
    logic [XW-1:0] xc_next;
    logic [DW-1:0] ya_next;
    logic [DW-1:0] yb_next;

    always_comb
    begin
        if (s3_sb_reg.mode == DIR_HSL2RGB)
        begin
            xa_next = chan_dividend(s3_p_reg, s3_span_reg, s3_wr_reg);
            xb_next = chan_dividend(s3_p_reg, s3_span_reg, s3_wg_reg);
            xc_next = chan_dividend(s3_p_reg, s3_span_reg, s3_wb_reg);
            ya_next = CH_DIV;
            yb_next = CH_DIV;
        end
        else
        begin
            xa_next = s3_xhue_reg;
            xb_next = s3_xsat_reg;
            xc_next = '0;
            ya_next = s3_yhue_reg;
            yb_next = s3_ysat_reg;
        end
    end

    logic          s4_valid_reg;
    sb_t           s4_sb_reg;
    logic [XW-1:0] s4_xa_reg;
    logic [XW-1:0] s4_xb_reg;
    logic [XW-1:0] s4_xc_reg;
    logic [DW-1:0] s4_ya_reg;
    logic [DW-1:0] s4_yb_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s4_valid_reg <= 1'b0;
        end
        else
        begin
            s4_valid_reg <= s3_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        s4_sb_reg <= s3_sb_reg;
        s4_xa_reg <= xa_next;
        s4_xb_reg <= xb_next;
        s4_xc_reg <= xc_next;
        s4_ya_reg <= ya_next;
        s4_yb_reg <= yb_next;
    end

    // ------------------------------------------------------------------
    // Divider lanes. A gray pixel divides by zero here; its quotients are
    // meaningless and get replaced by zero at the output.
    // ------------------------------------------------------------------
    logic [QW-1:0] qa;
    logic [QW-1:0] qb;
    logic [QW-1:0] qc;

    rhc_div #(
        .XW     (XW),
        .DW     (DW),
        .QW     (QW),
        .SPS    (DIV_STEPS),
        .STAGES (DS)
    ) u_div_a (
        .clk (clk),
        .x   (s4_xa_reg),
        .y   (s4_ya_reg),
        .q   (qa)
    );

    rhc_div #(
        .XW     (XW),
        .DW     (DW),
        .QW     (QW),
        .SPS    (DIV_STEPS),
        .STAGES (DS)
    ) u_div_b (
        .clk (clk),
        .x   (s4_xb_reg),
        .y   (s4_yb_reg),
        .q   (qb)
    );

    rhc_div #(
        .XW     (XW),
        .DW     (DW),
        .QW     (QW),
        .SPS    (DIV_STEPS),
        .STAGES (DS)
    ) u_div_c (
        .clk (clk),
        .x   (s4_xc_reg),
        .y   (CH_DIV),
        .q   (qc)
    );

    // Mode, gray flag and lightness ride alongside the divider stages.
    logic dv_valid_reg [DS];
    sb_t  dv_sb_reg    [DS];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < DS; i++)
            begin
                dv_valid_reg[i] <= 1'b0;
            end
        end
        else
        begin
            dv_valid_reg[0] <= s4_valid_reg;
            for (int i = 1; i < DS; i++)
            begin
                dv_valid_reg[i] <= dv_valid_reg[i-1];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        dv_sb_reg[0] <= s4_sb_reg;
        for (int i = 1; i < DS; i++)
        begin
            dv_sb_reg[i] <= dv_sb_reg[i-1];
        end
    end

    // ------------------------------------------------------------------
    // Output stage: hue wrap, saturation to the channel range, and zeros for
    // the fields the selected mode does not produce.
    // ------------------------------------------------------------------
    sb_t              out_sb;
    logic [QW-1:0]    hue_wrap;
    logic [HUE_W-1:0] hue_next;
    logic [N-1:0]     sat_next;
    logic [N-1:0]     light_next;
    logic [N-1:0]     red_next;
    logic [N-1:0]     green_next;
    logic [N-1:0]     blue_next;

    always_comb
    begin
        out_sb   = dv_sb_reg[DS-1];
        // A hue that rounds to a full turn reads as zero.
        hue_wrap = (qa >= QW'(HUE_TURN)) ? qa - QW'(HUE_TURN) : qa;
        if (out_sb.mode == DIR_HSL2RGB)
        begin
            hue_next   = '0;
            sat_next   = '0;
            light_next = '0;
            red_next   = sat_ch(qa);
            green_next = sat_ch(qb);
            blue_next  = sat_ch(qc);
        end
        else
        begin
            hue_next   = out_sb.gray ? '0 : hue_wrap[HUE_W-1:0];
            sat_next   = out_sb.gray ? '0 : sat_ch(qb);
            light_next = out_sb.light;
            red_next   = '0;
            green_next = '0;
            blue_next  = '0;
        end
    end

    logic             done_reg;
    logic [HUE_W-1:0] hue_out_reg;
    logic [N-1:0]     sat_out_reg;
    logic [N-1:0]     light_out_reg;
    logic [N-1:0]     red_out_reg;
    logic [N-1:0]     green_out_reg;
    logic [N-1:0]     blue_out_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= dv_valid_reg[DS-1];
        end
    end

    always_ff @(posedge clk)
    begin
        hue_out_reg   <= hue_next;
        sat_out_reg   <= sat_next;
        light_out_reg <= light_next;
        red_out_reg   <= red_next;
        green_out_reg <= green_next;
        blue_out_reg  <= blue_next;
    end

    assign done      = done_reg;
    assign hue_out   = hue_out_reg;
    assign sat_out   = sat_out_reg;
    assign light_out = light_out_reg;
    assign red_out   = red_out_reg;
    assign green_out = green_out_reg;
    assign blue_out  = blue_out_reg;

endmodule

// ----- rtl/rhc_checker.sv -----
// ----------------------------------------------------------------------------
// RGB/HSL converter port checker
// Watches the core's ports for result timing and result field consistency.
// ----------------------------------------------------------------------------
module rhc_checker #(
    parameter int CHANNEL_BITS = 8
) (
    input logic                      clk,
    input logic                      rst_n,
    input logic                      start,
    input logic                      busy,
    input logic                      done,
    input logic [rhc_pkg::HUE_W-1:0] hue_out,
    input logic [CHANNEL_BITS-1:0]   sat_out,
    input logic [CHANNEL_BITS-1:0]   light_out,
    input logic [CHANNEL_BITS-1:0]   red_out,
    input logic [CHANNEL_BITS-1:0]   green_out,
    input logic [CHANNEL_BITS-1:0]   blue_out
);

    import rhc_pkg::*;

    localparam int LAT = core_latency(CHANNEL_BITS);

    // Every result traces back to a transaction a fixed number of cycles ago.
    a_done_has_source: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(start && !busy, LAT))
        else $error("result strobe without a matching accepted transaction");

    a_hue_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (hue_out < HUE_TURN))
        else $error("hue result beyond one turn");

    // A result with any RGB channel set comes from HSL to RGB mode.
    a_mode_fields: assert property (@(posedge clk) disable iff (!rst_n)
        (done && (red_out != 0 || green_out != 0 || blue_out != 0))
        |-> (hue_out == 0 && sat_out == 0 && light_out == 0))
        else $error("both result groups nonzero in one transaction");

endmodule

bind rgb_hsl_color_converter_core rhc_checker #(
    .CHANNEL_BITS (CHANNEL_BITS)
) u_rhc_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .done      (done),
    .hue_out   (hue_out),
    .sat_out   (sat_out),
    .light_out (light_out),
    .red_out   (red_out),
    .green_out (green_out),
    .blue_out  (blue_out)
);

// ----- bench/tb_rgb_hsl_color_converter_core.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Testbench for the RGB/HSL color converter core
// A queue of pixels drives the core through its start/busy handshake. A local
// fixed-point color model works out each expected pixel, and the done strobe
// is checked against it field by field. The run covers both directions with
// phases of random sender idling.
// ----------------------------------------------------------------------------
module tb_rgb_hsl_color_converter_core;

    import rhc_pkg::*;

    localparam int CB = 8;
    localparam int CM = (1 << CB) - 1;
    localparam int LATENCY = 8;
    localparam int CYCLE_LIMIT = 400000;

    typedef struct packed {
        logic [CB-1:0]    red;
        logic [CB-1:0]    green;
        logic [CB-1:0]    blue;
        logic [HUE_W-1:0] hue;
        logic [CB-1:0]    sat;
        logic [CB-1:0]    light;
    } pixel_t;

    typedef struct packed {
        logic [HUE_W-1:0] hue;
        logic [CB-1:0]    sat;
        logic [CB-1:0]    light;
        logic [CB-1:0]    red;
        logic [CB-1:0]    green;
        logic [CB-1:0]    blue;
    } color_t;

    logic             clk = 1'b0;
    logic             rst_n = 1'b0;
    logic             cfg_valid = 1'b0;
    logic             cfg_ready;
    logic             cfg_data = 1'b0;
    logic             start = 1'b0;
    logic             busy;
    logic [CB-1:0]    red_in = '0, green_in = '0, blue_in = '0;
    logic [HUE_W-1:0] hue_in = '0;
    logic [CB-1:0]    sat_in = '0, light_in = '0;
    logic             done;
    logic [HUE_W-1:0] hue_out;
    logic [CB-1:0]    sat_out, light_out, red_out, green_out, blue_out;

    pixel_t pixel_queue[$];
    color_t expected_colors[$];
    logic   model_direction = DIR_RGB2HSL;
    logic   cfg_pending = 1'b0;
    logic   cfg_value = 1'b0;
    int     idle_percent = 0;
    int     mismatch_count = 0;
    int     cycle_count = 0;

    always #4 clk = ~clk;

    rgb_hsl_color_converter_core #(.CHANNEL_BITS(CB)) u_top (
        .clk(clk), .rst_n(rst_n), .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_data(cfg_data), .start(start), .busy(busy), .red_in(red_in),
        .green_in(green_in), .blue_in(blue_in), .hue_in(hue_in), .sat_in(sat_in),
        .light_in(light_in), .done(done), .hue_out(hue_out), .sat_out(sat_out),
        .light_out(light_out), .red_out(red_out), .green_out(green_out),
        .blue_out(blue_out)
    );

    // Rounded division with ties going upward.
    function automatic longint div_round(longint num, longint den);
        return (2 * num + den) / (2 * den);
    endfunction

    function automatic longint clamp_channel(longint v);
        return (v > CM) ? CM : v;
    endfunction

    // One output channel of the piecewise hue rule. The bounds P and Q are
    // scaled by the channel maximum squared.
    function automatic longint channel_from_hue(longint p, longint q, int t);
        longint den;
        den = 240 * CM;
        if (t < 0) t += 1440;
        if (t > 1440) t -= 1440;
        if (t < 240) return clamp_channel(div_round(240 * p + (q - p) * t, den));
        if (t < 720) return clamp_channel(div_round(q, CM));
        if (t < 960) return clamp_channel(div_round(240 * p + (q - p) * (960 - t), den));
        return clamp_channel(div_round(p, CM));
    endfunction

    function automatic color_t convert_pixel(pixel_t px, logic dir);
        color_t c;
        longint r, g, b, mx, mn, sum, d, den, num, h, s, l, q, p;
        c = '0;
        if (dir == DIR_RGB2HSL) begin
            r = px.red;
            g = px.green;
            b = px.blue;
            mx = (r > g) ? ((r > b) ? r : b) : ((g > b) ? g : b);
            mn = (r < g) ? ((r < b) ? r : b) : ((g < b) ? g : b);
            sum = mx + mn;
            c.light = clamp_channel((sum + 1) >> 1);
            if (mx != mn) begin
                d = mx - mn;
                den = (sum > CM) ? 2 * CM - sum : sum;
                c.sat = clamp_channel(div_round(CM * d, den));
                if (mx == r) num = 240 * (g - b) + ((g < b) ? 1440 * d : 0);
                else if (mx == g) num = 240 * (b - r) + 480 * d;
                else num = 240 * (r - g) + 960 * d;
                if (num < 0) num = 0;
                h = div_round(num, d);
                c.hue = h % 1440;
            end
        end
        else begin
            h = px.hue % 1440;
            s = px.sat;
            l = px.light;
            if (s == 0) begin
                c.red = l;
                c.green = l;
                c.blue = l;
            end
            else begin
                if (2 * l < CM) q = l * (CM + s);
                else q = l * CM + s * CM - l * s;
                p = 2 * l * CM - q;
                c.red = channel_from_hue(p, q, int'(h) + 480);
                c.green = channel_from_hue(p, q, int'(h));
                c.blue = channel_from_hue(p, q, int'(h) - 480);
            end
        end
        return c;
    endfunction

    task automatic report_mismatch(string field, int got, int want);
        $display("mismatch on %s: got %0d, expected %0d", field, got, want);
        mismatch_count++;
    endtask

    // Driver: one pixel per accepted transaction. The expectation is queued at
    // the accepting edge, using the direction that the model holds then.
    always @(posedge clk) begin
        if (rst_n) begin
            if (cfg_valid && cfg_ready) begin
                model_direction <= cfg_data;
                cfg_valid <= 1'b0;
            end
            else if (cfg_pending && !cfg_valid) begin
                cfg_valid <= 1'b1;
                cfg_data <= cfg_value;
                cfg_pending <= 1'b0;
            end
            if (start && !busy)
                expected_colors.push_back(convert_pixel(
                    {red_in, green_in, blue_in, hue_in, sat_in, light_in},
                    model_direction));
            if (!start || !busy) begin
                if (pixel_queue.size() > 0 && $urandom_range(99) >= idle_percent) begin
                    pixel_t px;
                    px = pixel_queue.pop_front();
                    start <= 1'b1;
                    {red_in, green_in, blue_in, hue_in, sat_in, light_in} <= px;
                end
                else begin
                    start <= 1'b0;
                end
            end
        end
    end

    // Monitor: the done strobe cannot be held off, so each pulse is checked.
    always @(posedge clk) begin
        color_t want;
        cycle_count <= cycle_count + 1;
        if (rst_n && done) begin
            if (expected_colors.size() == 0) begin
                $display("done strobe with no pixel outstanding");
                mismatch_count++;
            end
            else begin
                want = expected_colors.pop_front();
                if (hue_out !== want.hue) report_mismatch("hue_out", hue_out, want.hue);
                if (sat_out !== want.sat) report_mismatch("sat_out", sat_out, want.sat);
                if (light_out !== want.light)
                    report_mismatch("light_out", light_out, want.light);
                if (red_out !== want.red) report_mismatch("red_out", red_out, want.red);
                if (green_out !== want.green)
                    report_mismatch("green_out", green_out, want.green);
                if (blue_out !== want.blue) report_mismatch("blue_out", blue_out, want.blue);
            end
        end
    end

    always @(posedge clk) begin
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    task automatic push_pixel(int r, int g, int b, int h, int s, int l);
        pixel_t px;
        px = {r[CB-1:0], g[CB-1:0], b[CB-1:0], h[HUE_W-1:0], s[CB-1:0], l[CB-1:0]};
        pixel_queue.push_back(px);
    endtask

    task automatic push_random(int count);
        int v;
        repeat (count) begin
            v = $urandom_range(9);
            // Mostly full-range pixels; some gray ones and hues past a full turn.
            if (v == 0) begin
                int k;
                k = $urandom_range(CM);
                push_pixel(k, k, k, $urandom_range(2047), 0, $urandom_range(CM));
            end
            else begin
                push_pixel($urandom_range(CM), $urandom_range(CM), $urandom_range(CM),
                           (v == 1) ? $urandom_range(2047) : $urandom_range(1439),
                           $urandom_range(CM), $urandom_range(CM));
            end
        end
    endtask

    // Waits until every pixel has been taken and checked, then lets the
    // pipeline drain before the direction may change.
    task automatic drain_pipeline();
        while (pixel_queue.size() > 0 || start || expected_colors.size() > 0)
            @(posedge clk);
        repeat (LATENCY + 2) @(posedge clk);
    endtask

    task automatic write_direction(logic dir);
        cfg_value = dir;
        cfg_pending = 1'b1;
        while (cfg_pending || cfg_valid) @(posedge clk);
        @(posedge clk);
    endtask

    task automatic run_directed(logic dir);
        write_direction(dir);
        idle_percent = 0;
        push_pixel(0, 0, 0, 0, 0, 0);
        push_pixel(CM, CM, CM, 1439, CM, CM);
        push_pixel(CM, 0, 0, 1440, CM, CM / 2);
        push_pixel(0, CM, 0, 2047, CM, 128);
        push_pixel(0, 0, CM, 240, 1, 1);
        push_pixel(CM, 0, 1, 720, CM, 254);
        push_pixel(CM, CM, 0, 960, 128, 127);
        push_pixel(0, CM, CM, 480, CM, 0);
        push_pixel(CM, 0, CM, 1200, 200, 60);
        push_pixel(100, 100, 100, 1439, 0, 77);
        push_pixel(128, 127, 127, 1, CM, CM);
        push_pixel(1, 0, 0, 1919, 100, 200);
        drain_pipeline();
    endtask

    initial begin
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        run_directed(DIR_RGB2HSL);
        run_directed(DIR_HSL2RGB);
        // Random phases: back to back, heavy sender idling, then moderate.
        for (int ph = 0; ph < 6; ph++) begin
            write_direction(ph[0]);
            idle_percent = (ph < 2) ? 0 : ((ph < 4) ? 80 : 34);
            push_random(170);
            drain_pipeline();
        end
        if (mismatch_count == 0) begin
            $display("TB_OK");
        end
        else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule
